>>> rtl/bpe_pkg.sv
// Shared types and constants for the byte-pair merge tokenizer.
// No dependencies; bpe_front, bpe_back, the top level, the checker and the bench import this package.
package bpe_pkg;

  localparam int LEN_W = 7;
  localparam int IDX_W = 6;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] NO_RANK    = 32'hFFFF_FFFF;

  localparam logic [4:0] CFG_RESET = 5'd18;
  localparam logic [4:0] MIN_LOG2  = 5'd4;

  localparam logic REQ_INSERT = 1'b0;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_NO_VOCAB   = 3'd1;
  localparam logic [2:0] STAT_TOO_LONG   = 3'd2;
  localparam logic [2:0] STAT_TABLE_FULL = 3'd3;
  localparam logic [2:0] STAT_POOL_FULL  = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [LEN_W-1:0]  len;
    logic              ov;
    logic [31:0]       rank;
    logic              bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        data;
  } gwr_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_A,
    S_HASH_D,
    S_HASH_END,
    S_PROBE_A,
    S_PROBE_D,
    S_NEXT,
    S_CMP_A,
    S_CMP_D,
    S_INS_CHK,
    S_COPY_A,
    S_COPY_D,
    S_INS_DONE,
    S_INIT,
    S_INIT_W,
    S_SCAN_GO,
    S_SCAN_A,
    S_SCAN_D,
    S_SCAN_END,
    S_MERGE,
    S_MERGE_W1,
    S_MERGE_W2,
    S_FIN_FIND,
    S_FIN_TOK,
    S_EMIT_FIND,
    S_EMIT_A,
    S_EMIT_D,
    S_OUT,
    S_POP
  } state_t;

endpackage

>>> rtl/bpe_if.sv
// Valid/ready channel interfaces for input bytes and output tokens.
// No dependencies.
interface bpe_byte_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic        last;
  logic [31:0] rank;

  modport source (output valid, req_type, data_byte, last, rank, input ready);
  modport sink (input valid, req_type, data_byte, last, rank, output ready);
endinterface

interface bpe_tok_if;
  logic        valid;
  logic        ready;
  logic [31:0] token_id;
  logic        token_last;
  logic [2:0]  status;

  modport source (output valid, token_id, token_last, status, input ready);
  modport sink (input valid, token_id, token_last, status, output ready);
endinterface

>>> rtl/bpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bpe_front.sv
// Front end: gathers bytes into a two-bank buffer and queues closed jobs.
// Depends on bpe_pkg and bpe_if.
module bpe_front #(
  parameter int MAX_PIECE = 64
) (
  input  logic          clk,
  input  logic          rst,
  bpe_byte_if.sink      byte_ch,
  input  logic          busy,
  output bpe_pkg::gwr_t gw,
  output logic          job_valid,
  output bpe_pkg::job_t job,
  input  logic          pop
);
  import bpe_pkg::*;

  localparam int LW = $clog2(MAX_PIECE + 1);

  logic [LW-1:0] gcount;
  logic          ov;
  logic          wptr;
  logic          rptr;
  logic [1:0]    qcount;
  job_t          q [2];
  job_t          entry;
  logic          full;
  logic          accept;
  logic          push;

  assign full   = gcount == LW'(MAX_PIECE);
  assign accept = byte_ch.valid && byte_ch.ready;
  assign push   = accept && byte_ch.last;

  assign byte_ch.ready = (qcount != 2'd2) && !busy;

  assign gw.en   = accept && !full;
  assign gw.bank = wptr;
  assign gw.idx  = IDX_W'(gcount);
  assign gw.data = byte_ch.data_byte;

  always_comb begin
    entry.req_type = byte_ch.req_type;
    entry.len      = full ? LEN_W'(gcount) : LEN_W'(gcount + LW'(1));
    entry.ov       = ov || full;
    entry.rank     = byte_ch.rank;
    entry.bank     = wptr;
  end

  assign job_valid = qcount != 2'd0;
  assign job       = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      gcount <= '0;
      ov     <= 1'b0;
      wptr   <= 1'b0;
      rptr   <= 1'b0;
      qcount <= 2'd0;
    end else begin
      if (accept) begin
        if (push) begin
          gcount <= '0;
          ov     <= 1'b0;
          wptr   <= !wptr;
        end else if (full) begin
          ov <= 1'b1;
        end else begin
          gcount <= gcount + LW'(1);
        end
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   qcount <= qcount + 2'd1;
        2'b01:   qcount <= qcount - 2'd1;
        default: qcount <= qcount;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= entry;
    end
  end

endmodule

>>> rtl/bpe_back.sv
// Back end: hash table insert/lookup and the byte-pair merge sequencer.
// Depends on bpe_pkg, bpe_if and bpe_ram.
module bpe_back #(
  parameter int TABLE_SLOTS_LOG2 = 18,
  parameter int POOL_BYTES       = 2097152,
  parameter int MAX_PIECE        = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [4:0]                 cfg_l,
  input  logic                       job_valid,
  input  bpe_pkg::job_t              job,
  output logic                       pop,
  output logic                       busy,
  output logic [$clog2(MAX_PIECE):0] g_raddr,
  input  logic [7:0]                 g_rdata,
  bpe_tok_if.source                  tok_ch
);
  import bpe_pkg::*;

  localparam int TL    = TABLE_SLOTS_LOG2;
  localparam int LW    = $clog2(MAX_PIECE + 1);
  localparam int PW    = $clog2(MAX_PIECE);
  localparam int AP    = $clog2(POOL_BYTES);
  localparam int FW    = $clog2(POOL_BYTES + 1);
  localparam int SW    = 64 + AP + LW;
  localparam int SLOTS = 1 << TL;

  state_t st, st_next, ret;

  logic [TL-1:0]   clr;
  logic [TL-1:0]   entries;
  logic [FW-1:0]   pool_fill;
  logic [TL:0]     cap;
  logic [TL-1:0]   mask;
  logic [TL-1:0]   limit;

  logic [31:0]     h;
  logic [31:0]     hfix;
  logic [LW-1:0]   k;
  logic [LW-1:0]   sp_from;
  logic [LW-1:0]   sp_len;
  logic            ins;
  logic [TL-1:0]   idx;
  logic [TL:0]     probes;
  logic [31:0]     e_rank;
  logic [AP-1:0]   e_start;
  logic [31:0]     sp_res;

  logic [MAX_PIECE:0] alive;
  logic [LW-1:0]   p;
  logic [LW-1:0]   a;
  logic [LW-1:0]   q;
  logic [31:0]     best;
  logic [LW-1:0]   bp;
  logic [LW-1:0]   bpred;
  logic            bhas;
  logic [LW-1:0]   lp;
  logic            seen;
  logic [LW-1:0]   s1, s2, s3;
  logic [1:0]      scnt;

  logic            o_valid;
  logic [31:0]     o_id;
  logic            o_last;
  logic [2:0]      o_status;

  logic [LW-1:0]   jlen;
  logic [LW-1:0]   pos;
  logic [31:0]     scan_r;
  logic            last_probe;
  logic            pool_over;

  logic            call_go;
  logic [LW-1:0]   call_from;
  logic [LW-1:0]   call_to;
  state_t          call_ret;
  logic            call_ins;
  logic            out_go;
  logic [31:0]     out_id;
  logic            out_last;
  logic [2:0]      out_status;

  logic            slot_we;
  logic [TL-1:0]   slot_waddr;
  logic [SW-1:0]   slot_wdata;
  logic [TL-1:0]   slot_raddr;
  logic [SW-1:0]   slot_rd;
  logic            pool_we;
  logic [AP-1:0]   pool_waddr;
  logic [7:0]      pool_wdata;
  logic [AP-1:0]   pool_raddr;
  logic [7:0]      pool_rd;
  logic            pr_we;
  logic [PW-1:0]   pr_waddr;
  logic [31:0]     pr_wdata;
  logic [PW-1:0]   pr_raddr;
  logic [31:0]     pr_rd;

  logic [31:0]     s_hash;
  logic [31:0]     s_rank;
  logic [AP-1:0]   s_start;
  logic [LW-1:0]   s_len;

  bpe_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rd)
  );

  bpe_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
    .raddr(pool_raddr), .rdata(pool_rd)
  );

  bpe_ram #(.WIDTH(32), .DEPTH(MAX_PIECE)) u_pair (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rd)
  );

  assign cap   = (TL+1)'(1) << cfg_l;
  assign mask  = TL'(cap - (TL+1)'(1));
  assign limit = TL'((TL+2)'(3) << (cfg_l - 5'd2));

  assign s_hash  = slot_rd[SW-1 -: 32];
  assign s_rank  = slot_rd[SW-33 -: 32];
  assign s_start = slot_rd[LW +: AP];
  assign s_len   = slot_rd[LW-1:0];

  assign jlen       = job.len[LW-1:0];
  assign pos        = sp_from + k;
  assign hfix       = (h == 32'd0) ? 32'd1 : h;
  assign scan_r     = (p < jlen) ? pr_rd : NO_RANK;
  assign last_probe = (probes + (TL+1)'(1)) == cap;
  assign pool_over  = ({1'b0, pool_fill} + (FW+1)'(jlen)) > (FW+1)'(POOL_BYTES);

  assign busy = st == S_CLEAR;

  assign tok_ch.valid      = o_valid;
  assign tok_ch.token_id   = o_id;
  assign tok_ch.token_last = o_last;
  assign tok_ch.status     = o_status;

  always_comb begin
    call_go    = 1'b0;
    call_from  = '0;
    call_to    = '0;
    call_ret   = S_IDLE;
    call_ins   = 1'b0;
    out_go     = 1'b0;
    out_id     = 32'd0;
    out_last   = 1'b1;
    out_status = STAT_OK;
    slot_we    = 1'b0;
    slot_waddr = idx;
    slot_wdata = {h, job.rank, AP'(pool_fill), jlen};
    slot_raddr = idx;
    pool_we    = 1'b0;
    pool_waddr = AP'(pool_fill + FW'(k));
    pool_wdata = g_rdata;
    pool_raddr = e_start + AP'(k);
    pr_we      = 1'b0;
    pr_waddr   = PW'(p);
    pr_wdata   = sp_res;
    pr_raddr   = PW'(p);
    g_raddr    = {job.bank, PW'(pos)};
    pop        = 1'b0;
    case (st)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr;
        slot_wdata = '0;
      end
      S_IDLE: begin
        if (job_valid) begin
          if (job.ov) begin
            out_go     = 1'b1;
            out_status = STAT_TOO_LONG;
          end else if (job.req_type == REQ_INSERT) begin
            if (entries >= limit) begin
              out_go     = 1'b1;
              out_status = STAT_TABLE_FULL;
            end else begin
              call_go  = 1'b1;
              call_to  = jlen;
              call_ins = 1'b1;
            end
          end
        end
      end
      S_NEXT: begin
        if (last_probe && ins) begin
          out_go     = 1'b1;
          out_status = STAT_TABLE_FULL;
        end
      end
      S_INS_CHK: begin
        if (pool_over) begin
          out_go     = 1'b1;
          out_status = STAT_POOL_FULL;
        end else begin
          slot_we = 1'b1;
        end
      end
      S_COPY_A: g_raddr = {job.bank, PW'(k)};
      S_COPY_D: pool_we = 1'b1;
      S_INS_DONE: out_go = 1'b1;
      S_INIT: begin
        if ((LW+1)'(p) + (LW+1)'(2) <= (LW+1)'(jlen)) begin
          call_go   = 1'b1;
          call_from = p;
          call_to   = p + LW'(2);
          call_ret  = S_INIT_W;
        end else begin
          pr_we    = 1'b1;
          pr_waddr = PW'(jlen - LW'(1));
          pr_wdata = NO_RANK;
        end
      end
      S_INIT_W: pr_we = 1'b1;
      S_MERGE: begin
        if (scnt == 2'd3) begin
          call_go   = 1'b1;
          call_from = bp;
          call_to   = s3;
          call_ret  = S_MERGE_W1;
        end
      end
      S_MERGE_W1: begin
        pr_we    = 1'b1;
        pr_waddr = PW'(bp);
        if (bhas) begin
          call_go   = 1'b1;
          call_from = bpred;
          call_to   = s2;
          call_ret  = S_MERGE_W2;
        end
      end
      S_MERGE_W2: begin
        pr_we    = 1'b1;
        pr_waddr = PW'(bpred);
      end
      S_FIN_FIND: begin
        if (alive[q]) begin
          call_go   = 1'b1;
          call_from = a;
          call_to   = q;
          call_ret  = S_FIN_TOK;
        end
      end
      S_FIN_TOK: begin
        if (sp_res == NO_RANK) begin
          out_go     = 1'b1;
          out_status = STAT_NO_VOCAB;
        end else begin
          pr_we    = 1'b1;
          pr_waddr = PW'(a);
        end
      end
      S_EMIT_A: pr_raddr = PW'(a);
      S_EMIT_D: begin
        out_go   = 1'b1;
        out_id   = pr_rd;
        out_last = q == jlen;
      end
      S_POP: pop = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    st_next = st;
    if (out_go) begin
      st_next = S_OUT;
    end else if (call_go) begin
      st_next = S_HASH_A;
    end else begin
      case (st)
        S_CLEAR:    if (clr == '1) st_next = S_IDLE;
        S_IDLE:     if (job_valid) st_next = S_INIT;
        S_HASH_A:   st_next = S_HASH_D;
        S_HASH_D:   st_next = (k + LW'(1) == sp_len) ? S_HASH_END : S_HASH_A;
        S_HASH_END: st_next = S_PROBE_A;
        S_PROBE_A:  st_next = S_PROBE_D;
        S_PROBE_D: begin
          if (s_hash == 32'd0) begin
            st_next = ins ? S_INS_CHK : ret;
          end else if (!ins && s_hash == h && s_len == sp_len) begin
            st_next = S_CMP_A;
          end else begin
            st_next = S_NEXT;
          end
        end
        S_NEXT:     st_next = last_probe ? ret : S_PROBE_A;
        S_CMP_A:    st_next = S_CMP_D;
        S_CMP_D: begin
          if (pool_rd != g_rdata) begin
            st_next = S_NEXT;
          end else if (k + LW'(1) == sp_len) begin
            st_next = ret;
          end else begin
            st_next = S_CMP_A;
          end
        end
        S_INS_CHK:  st_next = S_COPY_A;
        S_COPY_A:   st_next = S_COPY_D;
        S_COPY_D:   st_next = (k + LW'(1) == jlen) ? S_INS_DONE : S_COPY_A;
        S_INIT:     st_next = S_SCAN_GO;
        S_INIT_W:   st_next = S_INIT;
        S_SCAN_GO:  st_next = S_SCAN_A;
        S_SCAN_A:   st_next = S_SCAN_D;
        S_SCAN_D:   st_next = (p == jlen) ? S_SCAN_END : S_SCAN_A;
        S_SCAN_END: st_next = (best == NO_RANK) ? S_FIN_FIND : S_MERGE;
        S_MERGE:    st_next = S_MERGE_W1;
        S_MERGE_W1: st_next = S_SCAN_GO;
        S_MERGE_W2: st_next = S_SCAN_GO;
        S_FIN_FIND: st_next = S_FIN_FIND;
        S_FIN_TOK:  st_next = (q == jlen) ? S_EMIT_FIND : S_FIN_FIND;
        S_EMIT_FIND: if (alive[q]) st_next = S_EMIT_A;
        S_EMIT_A:   st_next = S_EMIT_D;
        S_OUT: begin
          if (tok_ch.ready) st_next = o_last ? S_POP : S_EMIT_FIND;
        end
        S_POP:      st_next = S_IDLE;
        default:    st_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      clr       <= '0;
      entries   <= '0;
      pool_fill <= '0;
      o_valid   <= 1'b0;
    end else begin
      st <= st_next;
      if (out_go) begin
        o_valid  <= 1'b1;
        o_id     <= out_id;
        o_last   <= out_last;
        o_status <= out_status;
      end
      if (call_go) begin
        sp_from <= call_from;
        sp_len  <= call_to - call_from;
        k       <= '0;
        h       <= FNV_OFFSET;
        ret     <= call_ret;
        ins     <= call_ins;
      end
      case (st)
        S_CLEAR: clr <= clr + TL'(1);
        S_IDLE: begin
          p <= '0;
          for (int i = 0; i <= MAX_PIECE; i++) begin
            alive[i] <= (LW+1)'(i) <= (LW+1)'(jlen);
          end
        end
        S_HASH_D: begin
          h <= (h ^ 32'(g_rdata)) * FNV_PRIME;
          k <= k + LW'(1);
        end
        S_HASH_END: begin
          h      <= hfix;
          idx    <= hfix[TL-1:0] & mask;
          probes <= '0;
        end
        S_PROBE_D: begin
          e_rank  <= s_rank;
          e_start <= s_start;
          k       <= '0;
          if (s_hash == 32'd0 && !ins) sp_res <= NO_RANK;
        end
        S_NEXT: begin
          probes <= probes + (TL+1)'(1);
          idx    <= (idx + TL'(1)) & mask;
          if (last_probe && !ins) sp_res <= NO_RANK;
        end
        S_CMP_D: begin
          k <= k + LW'(1);
          if (pool_rd == g_rdata && k + LW'(1) == sp_len) sp_res <= e_rank;
        end
        S_INS_CHK: k <= '0;
        S_COPY_D:  k <= k + LW'(1);
        S_INS_DONE: begin
          pool_fill <= pool_fill + FW'(jlen);
          entries   <= entries + TL'(1);
        end
        S_INIT_W: p <= p + LW'(1);
        S_SCAN_GO: begin
          p    <= '0;
          best <= NO_RANK;
          seen <= 1'b0;
          scnt <= 2'd3;
        end
        S_SCAN_D: begin
          if (alive[p]) begin
            if (scan_r < best) begin
              best  <= scan_r;
              bp    <= p;
              bpred <= lp;
              bhas  <= seen;
              scnt  <= 2'd0;
            end else begin
              case (scnt)
                2'd0:    s1 <= p;
                2'd1:    s2 <= p;
                2'd2:    s3 <= p;
                default: ;
              endcase
              if (scnt != 2'd3) scnt <= scnt + 2'd1;
            end
            lp   <= p;
            seen <= 1'b1;
          end
          if (p != jlen) p <= p + LW'(1);
        end
        S_SCAN_END: begin
          a <= '0;
          q <= LW'(1);
        end
        S_MERGE: begin
          alive[s1] <= 1'b0;
          if (scnt != 2'd3) sp_res <= NO_RANK;
        end
        S_FIN_FIND: if (!alive[q]) q <= q + LW'(1);
        S_FIN_TOK: begin
          if (q == jlen) begin
            a <= '0;
            q <= LW'(1);
          end else begin
            a <= q;
            q <= q + LW'(1);
          end
        end
        S_EMIT_FIND: if (!alive[q]) q <= q + LW'(1);
        S_OUT: begin
          if (tok_ch.ready) begin
            o_valid <= 1'b0;
            a       <= q;
            q       <= q + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/bpe_merge_with_hash_vocab.sv
// Byte-pair merge tokenizer with an FNV-1a hashed vocabulary: top level.
// Depends on bpe_pkg, bpe_if, bpe_ram, bpe_front and bpe_back.
// Throughput: non-closing bytes are taken one per cycle while the job queue is not full and
//   no clearing pass runs; each lookup hashes the piece, reads each probed slot, compares
//   the bytes where the hash matches and steps on; an insert adds the pool copy, and an
//   encode runs a merge scan per merge until no pair has a rank, so work is set by the
//   shared lookup.
// Reset: synchronous; a clearing pass writes all 2^TABLE_SLOTS_LOG2 slots,
//   one per cycle, and no byte is taken until it ends.
module bpe_merge_with_hash_vocab #(
  parameter int TABLE_SLOTS_LOG2 = 18,
  parameter int POOL_BYTES       = 2097152,
  parameter int MAX_PIECE        = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  bpe_byte_if.sink   byte_ch,
  bpe_tok_if.source  tok_ch
);
  import bpe_pkg::*;

  localparam int PW = $clog2(MAX_PIECE);

  logic [4:0]  table_size_log2;
  logic [4:0]  cfg_l;
  gwr_t        gw;
  job_t        job;
  logic        job_valid;
  logic        pop;
  logic        busy;
  logic [PW:0] g_raddr;
  logic [7:0]  g_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size_log2 <= CFG_RESET;
    end else if (cfg_wr_en) begin
      table_size_log2 <= cfg_wr_data;
    end
  end

  always_comb begin
    if (table_size_log2 < MIN_LOG2) begin
      cfg_l = MIN_LOG2;
    end else if (table_size_log2 > 5'(TABLE_SLOTS_LOG2)) begin
      cfg_l = 5'(TABLE_SLOTS_LOG2);
    end else begin
      cfg_l = table_size_log2;
    end
  end

  bpe_ram #(.WIDTH(8), .DEPTH(2 << PW)) u_gather (
    .clk(clk), .we(gw.en), .waddr({gw.bank, gw.idx[PW-1:0]}), .wdata(gw.data),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  bpe_front #(.MAX_PIECE(MAX_PIECE)) u_front (
    .clk(clk), .rst(rst), .byte_ch(byte_ch), .busy(busy), .gw(gw),
    .job_valid(job_valid), .job(job), .pop(pop)
  );

  bpe_back #(
    .TABLE_SLOTS_LOG2(TABLE_SLOTS_LOG2), .POOL_BYTES(POOL_BYTES), .MAX_PIECE(MAX_PIECE)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_l(cfg_l), .job_valid(job_valid), .job(job),
    .pop(pop), .busy(busy), .g_raddr(g_raddr), .g_rdata(g_rdata), .tok_ch(tok_ch)
  );

endmodule

>>> rtl/bpe_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
// Depends on bpe_pkg.
module bpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] token_id,
  input logic        token_last,
  input logic [2:0]  status
);
  import bpe_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_id) && $stable(status)
      && $stable(token_last))
    else $error("stalled word changed");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> token_last && token_id == 32'd0)
    else $error("status word not a lone last word");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= STAT_POOL_FULL)
    else $error("status out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("active right after reset");

endmodule

bind bpe_merge_with_hash_vocab bpe_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(byte_ch.ready), .out_valid(tok_ch.valid),
  .out_ready(tok_ch.ready), .token_id(tok_ch.token_id),
  .token_last(tok_ch.token_last), .status(tok_ch.status)
);

>>> bench/testbench.sv
// Self-checking bench for bpe_merge_with_hash_vocab: vocabulary inserts and merge encodes.
// Drives byte words with random gaps and stalls, and predicts every token word in the bench.
// Depends on bpe_pkg, bpe_if and bpe_merge_with_hash_vocab from the rtl folder.
`timescale 1ns / 100ps

module testbench;
  import bpe_pkg::*;

  localparam logic REQ_ENCODE = 1'b1;
  localparam int unsigned POOL_LIMIT = 2097152;
  localparam int unsigned TABLE_MAX_LOG2 = 18;

  typedef logic [7:0] bytes_t[$];
  typedef struct {
    logic        req;
    logic [7:0]  data;
    logic        lst;
    logic [31:0] rk;
  } byte_item_t;
  typedef struct {
    logic [31:0] id;
    logic        lst;
    logic [2:0]  st;
  } tok_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [4:0] cfg_wr_data;

  bpe_byte_if bch();
  bpe_tok_if tch();

  bpe_merge_with_hash_vocab DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_ch(bch),
    .tok_ch(tch)
  );

  logic [31:0] tbl_hash[int unsigned];
  logic [31:0] tbl_rank[int unsigned];
  bytes_t tbl_key[int unsigned];
  int unsigned entries;
  int unsigned pool_fill;
  bytes_t gath;
  bit ovf;
  logic [4:0] cfg_val;

  byte_item_t pend[$];
  tok_t exp_toks[$];
  int n_acc, n_sent, n_res, n_seen, n_queued, errors;
  int gap, stall;
  bit no_idle;

  always #2 clk = ~clk;

  function automatic int unsigned eff_log2();
    int unsigned l;
    l = 32'(cfg_val);
    if (l < MIN_LOG2) l = MIN_LOG2;
    if (l > TABLE_MAX_LOG2) l = TABLE_MAX_LOG2;
    return l;
  endfunction

  function automatic logic [31:0] fnv1a(bytes_t k);
    logic [31:0] h;
    h = FNV_OFFSET;
    foreach (k[i]) h = (h ^ {24'd0, k[i]}) * FNV_PRIME;
    return (h == 32'd0) ? 32'd1 : h;
  endfunction

  function automatic logic [31:0] model_find(bytes_t k);
    int unsigned cap, mask, i, p;
    logic [31:0] h;
    bit same;
    cap = 1 << eff_log2();
    mask = cap - 1;
    h = fnv1a(k);
    i = h & mask;
    for (p = 0; p < cap; p++) begin
      if (!tbl_hash.exists(i)) return NO_RANK;
      if (tbl_hash[i] == h && tbl_key[i].size() == k.size()) begin
        same = 1;
        foreach (k[j]) if (tbl_key[i][j] != k[j]) same = 0;
        if (same) return tbl_rank[i];
      end
      i = (i + 1) & mask;
    end
    return NO_RANK;
  endfunction

  function automatic logic [2:0] model_store(bytes_t k, logic [31:0] rk);
    int unsigned cap, mask, i, p;
    logic [31:0] h;
    cap = 1 << eff_log2();
    mask = cap - 1;
    if (entries >= cap * 3 / 4) return STAT_TABLE_FULL;
    h = fnv1a(k);
    i = h & mask;
    for (p = 0; p < cap && tbl_hash.exists(i); p++) i = (i + 1) & mask;
    if (tbl_hash.exists(i)) return STAT_TABLE_FULL;
    if (pool_fill + k.size() > POOL_LIMIT) return STAT_POOL_FULL;
    tbl_hash[i] = h;
    tbl_rank[i] = rk;
    tbl_key[i] = k;
    pool_fill += k.size();
    entries++;
    return STAT_OK;
  endfunction

  function automatic void merge_and_emit(bytes_t k);
    int n, i, at, del, ntok;
    int bnd[65];
    logic [31:0] pr[64];
    logic [31:0] toks[64];
    logic [31:0] best;
    n = k.size() + 1;
    for (i = 0; i < n; i++) bnd[i] = i;
    for (i = 0; i + 2 < n; i++) pr[i] = model_find(k[bnd[i]:bnd[i+2]-1]);
    pr[n-2] = NO_RANK;
    forever begin
      best = NO_RANK;
      at = 0;
      for (i = 0; i + 2 < n; i++) begin
        if (pr[i] < best) begin
          best = pr[i];
          at = i;
        end
      end
      if (best == NO_RANK) break;
      del = at + 1;
      for (i = del; i + 1 < n; i++) bnd[i] = bnd[i+1];
      for (i = del; i + 2 < n; i++) pr[i] = pr[i+1];
      n--;
      pr[at] = (at + 2 < n) ? model_find(k[bnd[at]:bnd[at+2]-1]) : NO_RANK;
      if (at > 0)
        pr[at-1] = (at + 1 < n) ? model_find(k[bnd[at-1]:bnd[at+1]-1]) : NO_RANK;
    end
    ntok = n - 1;
    for (i = 0; i < ntok; i++) begin
      toks[i] = model_find(k[bnd[i]:bnd[i+1]-1]);
      if (toks[i] == NO_RANK) begin
        exp_toks.push_back('{32'd0, 1'b1, STAT_NO_VOCAB});
        return;
      end
    end
    for (i = 0; i < ntok; i++) exp_toks.push_back('{toks[i], i + 1 == ntok, STAT_OK});
  endfunction

  function automatic void take_byte(logic req, logic [7:0] data, logic lst, logic [31:0] rk);
    bytes_t k;
    if (gath.size() < 64) gath.push_back(data);
    else ovf = 1;
    if (!lst) return;
    k = gath;
    gath = {};
    if (ovf) begin
      ovf = 0;
      exp_toks.push_back('{32'd0, 1'b1, STAT_TOO_LONG});
    end else if (req == REQ_INSERT) begin
      exp_toks.push_back('{32'd0, 1'b1, model_store(k, rk)});
    end else begin
      merge_and_emit(k);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (bch.valid && bch.ready) begin
        take_byte(bch.req_type, bch.data_byte, bch.last, bch.rank);
        n_acc++;
      end
      if (tch.valid && tch.ready) begin
        n_res++;
        if (exp_toks.size() == 0) begin
          $display("%0t unexpected word: id %h last %b status %0d", $time,
                   tch.token_id, tch.token_last, tch.status);
          errors++;
        end else begin
          tok_t e;
          e = exp_toks.pop_front();
          if (e.id !== tch.token_id || e.lst !== tch.token_last || e.st !== tch.status) begin
            $display("%0t expected id %h last %b status %0d, got id %h last %b status %0d",
                     $time, e.id, e.lst, e.st, tch.token_id, tch.token_last, tch.status);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && n_acc == n_sent) begin
      if (gap > 0) begin
        bch.valid <= 1'b0;
        gap--;
      end else if (pend.size() > 0) begin
        byte_item_t it;
        it = pend.pop_front();
        bch.valid <= 1'b1;
        bch.req_type <= it.req;
        bch.data_byte <= it.data;
        bch.last <= it.lst;
        bch.rank <= it.rk;
        n_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 12);
      end else begin
        bch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (n_seen != n_res) begin
        n_seen = n_res;
        stall = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        tch.ready <= 1'b0;
        stall--;
      end else begin
        tch.ready <= 1'b1;
      end
    end
  end

  task automatic push_word(logic req, bytes_t k, logic [31:0] rk);
    foreach (k[i]) begin
      logic r;
      r = (i == k.size() - 1) ? req : logic'($urandom_range(0, 1));
      pend.push_back('{r, k[i], i == k.size() - 1, $urandom()});
      if (i == k.size() - 1) pend[$].rk = rk;
    end
    n_queued += k.size();
  endtask

  task automatic drain();
    while (!(pend.size() == 0 && n_acc == n_sent && exp_toks.size() == 0)) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_cfg(logic [4:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cfg_val = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic rand_phase(int n_items);
    int stop, len, pick;
    bytes_t k;
    logic [31:0] rk;
    stop = n_queued + n_items;
    no_idle = ($urandom_range(0, 3) == 0);
    while (n_queued < stop) begin
      k = {};
      pick = $urandom_range(0, 99);
      len = (pick < 40) ? $urandom_range(1, 3) : (pick < 90) ? $urandom_range(1, 8)
          : (pick < 95) ? $urandom_range(65, 70) : $urandom_range(1, 4);
      repeat (len) begin
        if (pick >= 95) k.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 19) == 0) k.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        else k.push_back(8'(8'h61 + $urandom_range(0, 5)));
      end
      rk = $urandom_range(0, 20) == 0 ? NO_RANK
         : $urandom_range(0, 10) == 0 ? $urandom() : $urandom_range(0, 1000);
      push_word(pick < 40 ? REQ_INSERT : pick < 90 ? REQ_ENCODE : logic'($urandom_range(0, 1)),
                k, rk);
    end
    drain();
  endtask

  initial begin
    bytes_t k;
    clk = 0;
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    bch.valid = 0;
    bch.req_type = 0;
    bch.data_byte = '0;
    bch.last = 0;
    bch.rank = '0;
    tch.ready = 0;
    cfg_val = CFG_RESET;
    entries = 0;
    pool_fill = 0;
    ovf = 0;
    gap = 0;
    stall = 0;
    no_idle = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int c = 0; c < 6; c++) push_word(REQ_INSERT, '{8'(8'h61 + c)}, 10 + c);
    push_word(REQ_INSERT, '{8'h00}, 32'd0);
    push_word(REQ_INSERT, '{8'hFF}, 32'hFFFF_FFFE);
    push_word(REQ_INSERT, '{8'h61, 8'h62}, 3);
    push_word(REQ_INSERT, '{8'h63, 8'h64}, 4);
    push_word(REQ_INSERT, '{8'h61, 8'h62, 8'h63, 8'h64}, 1);
    push_word(REQ_INSERT, '{8'h64, 8'h64}, NO_RANK);
    push_word(REQ_INSERT, '{8'h61, 8'h62}, 7);
    push_word(REQ_ENCODE, '{8'h61, 8'h62, 8'h63, 8'h64}, 0);
    push_word(REQ_ENCODE, '{8'h61, 8'h62, 8'h63, 8'h64, 8'h64}, 0);
    push_word(REQ_ENCODE, '{8'h00, 8'hFF}, 0);
    push_word(REQ_ENCODE, '{8'h61, 8'h62, 8'h7A}, 0);
    k = {};
    repeat (65) k.push_back(8'h61);
    push_word(REQ_INSERT, k, 5);
    k.push_back(8'h62);
    push_word(REQ_ENCODE, k, 0);
    k = {};
    repeat (32) begin
      k.push_back(8'h61);
      k.push_back(8'h62);
    end
    push_word(REQ_ENCODE, k, 0);
    drain();

    rand_phase(40);
    set_cfg(5'd4);
    rand_phase(15);
    set_cfg(5'd31);
    rand_phase(25);
    set_cfg(5'd0);
    rand_phase(15);
    set_cfg(5'd10);
    rand_phase(35);
    repeat (2000) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
